>>> design/splitmix64_byte_generator_core_assert.svh
// ----------------------------------------------------------------------------
// splitmix64 byte generator assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, idle during reset.
// ----------------------------------------------------------------------------
`ifndef SPLITMIX64_BYTE_GENERATOR_CORE_ASSERT_SVH
`define SPLITMIX64_BYTE_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SM_ASSERT_IMP(lbl, ante, cons, msg)
`define SM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/sm64_pkg.sv
// ----------------------------------------------------------------------------
// sm64_pkg
// Constants, codes and sequencer states of the splitmix64 byte generator.
// ----------------------------------------------------------------------------
package sm64_pkg;

  localparam int unsigned BYTES_PER_WORD = 8;
  localparam int unsigned WORD_W         = 8 * BYTES_PER_WORD;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned IDX_W          = $clog2(BYTES_PER_WORD);
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned HALF_W         = WORD_W / 2;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
  localparam logic [WORD_W-1:0] ZERO_SEED_SUB = 64'hCAFE_BABE_1234_5678;

  localparam int unsigned SHIFT_1 = 30;
  localparam int unsigned SHIFT_2 = 27;
  localparam int unsigned SHIFT_3 = 31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIER = 2'd1;

  // word source codes
  localparam logic [1:0] SRC_SOFT = 2'd0;
  localparam logic [1:0] SRC_RAND = 2'd1;
  localparam logic [1:0] SRC_SEED = 2'd2;

  // partial product steps of one 64-bit multiply
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XS1,
    ST_MUL1,
    ST_XS2,
    ST_MUL2,
    ST_FIN,
    ST_EMIT
  } state_e;

endpackage

>>> design/splitmix64_byte_generator_core.sv
// A hardware-source word shows its first byte in the cycle after the input transfer; a mixer
// word first passes XS1, MUL1, XS2, MUL2 and FIN (two 64-bit products, three passes each of one
// 32x32 multiplier). One byte per cycle goes out while out_stall_i is low; the next request is
// taken the cycle after the last byte; zero-byte requests are taken in idle and emit no bytes.
// Reset (async, active low): idle, tier 0, mixer state 0xCAFEBABE12345678.
// ----------------------------------------------------------------------------
// splitmix64 byte generator core
// Draws one 64-bit word per nonzero request from seed source, rand source or the
// splitmix64 mixer and emits its low bytes one per output transfer.
// ----------------------------------------------------------------------------
`include "splitmix64_byte_generator_core_assert.svh"

module splitmix64_byte_generator_core
  import sm64_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CNT_W-1:0]     byte_count_i,
  input  logic [WORD_W-1:0]    seed_sample_i,
  input  logic                 seed_ok_i,
  input  logic [WORD_W-1:0]    rand_sample_i,
  input  logic                 rand_ok_i,
  // byte channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_byte_o,
  output logic [1:0]           word_source_o
);

  state_e              state_q, state_d;
  logic [1:0]          step_q;
  logic [1:0]          tier_q;
  logic [WORD_W-1:0]   mix_state_q;
  logic [WORD_W-1:0]   z_q;
  logic [WORD_W-1:0]   acc_q, acc_d;
  logic [WORD_W-1:0]   word_q;
  logic [CNT_W-1:0]    count_q;
  logic [IDX_W-1:0]    idx_q;
  logic [1:0]          src_q;

  logic                in_xfer, out_xfer;
  logic                count_nz;
  logic [CNT_W-1:0]    count_sat;
  logic                use_seed, use_rand;
  logic                soft_draw;
  logic                is_last;
  logic [HALF_W-1:0]   mul_a, mul_b;
  logic [WORD_W-1:0]   mul_p;
  logic [WORD_W-1:0]   mul_k;

  // request decode
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_o && !out_stall_i;
  assign count_nz  = byte_count_i != '0;
  assign count_sat = (byte_count_i > CNT_W'(BYTES_PER_WORD)) ? CNT_W'(BYTES_PER_WORD)
                                                             : byte_count_i;
  assign use_seed  = tier_q[1] && seed_ok_i;
  assign use_rand  = !use_seed && (tier_q != 2'd0) && rand_ok_i;
  assign soft_draw = in_xfer && count_nz && !use_seed && !use_rand;
  assign is_last   = ({1'b0, idx_q} + CNT_W'(1)) == count_q;

  // shared 32x32 multiplier, one partial product per step
  assign mul_k = (state_q == ST_MUL1) ? MIX_MUL_A : MIX_MUL_B;
  assign mul_a = (step_q == STEP_HL) ? z_q[WORD_W-1:HALF_W] : z_q[HALF_W-1:0];
  assign mul_b = (step_q == STEP_LH) ? mul_k[WORD_W-1:HALF_W] : mul_k[HALF_W-1:0];
  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  always_comb begin
    if (step_q == STEP_LL) begin
      acc_d = mul_p;
    end else begin
      acc_d = acc_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && count_nz) begin
          state_d = (use_seed || use_rand) ? ST_EMIT : ST_XS1;
        end
      end
      ST_XS1:  state_d = ST_MUL1;
      ST_MUL1: if (step_q == STEP_HL) state_d = ST_XS2;
      ST_XS2:  state_d = ST_MUL2;
      ST_MUL2: if (step_q == STEP_HL) state_d = ST_FIN;
      ST_FIN:  state_d = ST_EMIT;
      ST_EMIT: if (out_xfer && is_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_EMIT);
    out_byte_o    = word_q[7:0];
    last_byte_o   = is_last;
    word_source_o = src_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_LL;
      tier_q      <= 2'd0;
      mix_state_q <= ZERO_SEED_SUB;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_MUL1 || state_q == ST_MUL2) && step_q != STEP_HL) begin
        step_q <= step_q + 2'd1;
      end else begin
        step_q <= STEP_LL;
      end
      if (cfg_we_i && cfg_idx_i == REG_TIER) begin
        tier_q <= cfg_wdata_i[1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_SEED) begin
        mix_state_q <= (cfg_wdata_i == '0) ? ZERO_SEED_SUB : cfg_wdata_i;
      end else if (soft_draw) begin
        mix_state_q <= mix_state_q + GOLDEN_GAMMA;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          count_q <= count_sat;
          idx_q   <= '0;
          if (use_seed) begin
            word_q <= seed_sample_i;
            src_q  <= SRC_SEED;
          end else if (use_rand) begin
            word_q <= rand_sample_i;
            src_q  <= SRC_RAND;
          end else begin
            src_q  <= SRC_SOFT;
          end
        end
      end
      ST_XS1:  z_q <= mix_state_q ^ (mix_state_q >> SHIFT_1);
      ST_MUL1: acc_q <= acc_d;
      ST_XS2:  z_q <= acc_q ^ (acc_q >> SHIFT_2);
      ST_MUL2: acc_q <= acc_d;
      ST_FIN:  word_q <= acc_q ^ (acc_q >> SHIFT_3);
      ST_EMIT: begin
        if (out_xfer) begin
          word_q <= word_q >> 8;
          idx_q  <= idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // checks
  `SM_ASSERT_NXT(a_more_bytes, out_xfer && !last_byte_o, out_valid_o, "byte stream broke early")
  `SM_ASSERT_NXT(a_back_idle, out_xfer && last_byte_o, !out_valid_o && !in_stall_o, "no return to idle")
  `SM_ASSERT_IMP(a_idx_range, out_valid_o, ({1'b0, idx_q} < count_q), "byte index past count")
  `SM_ASSERT_NXT(a_mix_hold, !cfg_we_i && !soft_draw, $stable(mix_state_q), "mixer state moved")
  `SM_ASSERT_IMP(a_step_range, 1'b1, step_q != 2'd3, "multiply step out of range")

endmodule
